// ===== sv/acg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_pkg: shared types and constants for the concurrency governor
// Word formats, host entry record, lookup result and register indexes.
// ----------------------------------------------------------------------------
package acg_pkg;

	localparam int HOST_ENTRIES = 64;
	localparam int IDX_W = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
	localparam int CNT_W = $clog2(HOST_ENTRIES + 1);

	localparam logic [31:0] GLOB_LIMIT_RST    = 32'd5000;
	localparam logic [15:0] INITIAL_LIMIT_RST = 16'd10;
	localparam logic [15:0] LIMIT_CAP_RST     = 16'd50;
	localparam logic [7:0]  TIMEOUT_TRIP_RST  = 8'd2;

	typedef enum logic [1:0] {
		OP_QUERY   = 2'd0,
		OP_CONSUME = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_GLOB_LIMIT    = 2'd0,
		CFG_INITIAL_LIMIT = 2'd1,
		CFG_LIMIT_CAP     = 2'd2,
		CFG_TIMEOUT_TRIP  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] host_id;
		logic        success;
	} task_word_t;

	typedef struct packed {
		logic        global_allow;
		logic        host_allow;
		logic [31:0] global_count;
		logic [15:0] host_count;
		logic [15:0] host_limit;
		logic        table_full;
	} res_word_t;

	typedef struct packed {
		logic [15:0] inflight;
		logic [15:0] limit;
		logic [7:0]  fail_run;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             table_full;
		logic             fresh;
		logic [IDX_W-1:0] idx;
	} lookup_t;

endpackage

// ===== sv/aimd_host_concurrency_governor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aimd_host_concurrency_governor: task admission with per-host AIMD limits
//
//   channel  direction  handshake              word
//   task     in         task_valid/task_ready  task_word_t
//   res      out        res_valid/res_ready    res_word_t
//   cfg      in         cfg_we                 cfg_idx, cfg_data
//
// One word per cycle unless res stalls; path: s1, s2 and result registers.
// Key match runs in s1, the entry table RAM is read at the s1->s2 edge and
// written back from s2, with a bypass for back-to-back words to one host.
// A stalled result stalls the whole pipeline; task_ready follows it.
// Reset clears counts and the entry fill count; no clearing pass.
// ----------------------------------------------------------------------------
module aimd_host_concurrency_governor import acg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        task_valid,
	output logic        task_ready,
	input  task_word_t  task_word,
	output logic        res_valid,
	input  logic        res_ready,
	output res_word_t   res_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	logic        en;
	logic [31:0] glob_limit_q;
	logic [15:0] initial_limit_q;
	logic [15:0] limit_cap_q;
	logic [7:0]  timeout_trip_q;

	logic        valid_s1;
	task_word_t  word_s1;
	lookup_t     lk;

	logic        valid_s2;
	task_word_t  word_s2;
	lookup_t     lk_s2;
	logic        fwd_s2;
	entry_t      fwd_data_s2;

	logic [ENTRY_W-1:0] rd_data;
	entry_t      cur;
	entry_t      nxt;
	entry_t      fresh_entry;
	logic [31:0] glob_q;
	logic [31:0] glob_nxt;

	logic        res_valid_q;
	res_word_t   res_word_q;
	res_word_t   res_d;

	assign en = !res_valid_q || res_ready;
	assign task_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glob_limit_q    <= GLOB_LIMIT_RST;
			initial_limit_q <= INITIAL_LIMIT_RST;
			limit_cap_q     <= LIMIT_CAP_RST;
			timeout_trip_q  <= TIMEOUT_TRIP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GLOB_LIMIT:    glob_limit_q    <= cfg_data;
				CFG_INITIAL_LIMIT: initial_limit_q <= cfg_data[15:0];
				CFG_LIMIT_CAP:     limit_cap_q     <= cfg_data[15:0];
				CFG_TIMEOUT_TRIP:  timeout_trip_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// s1: capture task word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= task_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= task_word;
		end
	end

	acg_lookup u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (valid_s1),
		.host_id (word_s1.host_id),
		.res     (lk)
	);

	acg_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (HOST_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (en && valid_s2 && !lk_s2.table_full),
		.waddr (lk_s2.idx),
		.wdata (nxt),
		.re    (en),
		.raddr (lk.idx),
		.rdata (rd_data)
	);

	// s2: update and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			fwd_s2   <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			fwd_s2   <= valid_s2 && !lk_s2.table_full && (lk_s2.idx == lk.idx);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s2     <= word_s1;
			lk_s2       <= lk;
			fwd_data_s2 <= nxt;
		end
	end

	assign fresh_entry.inflight = '0;
	assign fresh_entry.limit    = initial_limit_q;
	assign fresh_entry.fail_run = '0;

	assign cur = lk_s2.fresh ? fresh_entry : (fwd_s2 ? fwd_data_s2 : entry_t'(rd_data));

	acg_update u_update (
		.op           (word_s2.op),
		.success      (word_s2.success),
		.limit_cap    (limit_cap_q),
		.timeout_trip (timeout_trip_q),
		.glob_cur     (glob_q),
		.cur          (cur),
		.glob_nxt     (glob_nxt),
		.nxt          (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glob_q <= '0;
		end else if (en && valid_s2) begin
			glob_q <= glob_nxt;
		end
	end

	always_comb begin
		res_d.global_allow = glob_nxt < glob_limit_q;
		res_d.global_count = glob_nxt;
		res_d.table_full   = lk_s2.table_full;
		if (lk_s2.table_full) begin
			res_d.host_allow = 1'b0;
			res_d.host_count = '0;
			res_d.host_limit = '0;
		end else begin
			res_d.host_allow = nxt.inflight < nxt.limit;
			res_d.host_count = nxt.inflight;
			res_d.host_limit = nxt.limit;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_word_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	a_fwd_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && fwd_s2 |-> !lk_s2.fresh)
		else $error("bypass taken for a newly allocated entry");

	a_glob_moves_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(glob_q != $past(glob_q)) |-> $past(en && valid_s2))
		else $error("global count changed without an advancing word");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && lk_s2.table_full |-> !lk_s2.fresh)
		else $error("full table word also marked for allocation");

endmodule

// ===== sv/acg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_ram: generic single-write, single-read RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module acg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

// ===== sv/acg_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_lookup: host key table with parallel match and in-order allocation
// Matches the host id against every used entry; claims the next free entry
// for an unknown host, or flags the table as full.
// ----------------------------------------------------------------------------
module acg_lookup import acg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        valid,
	input  logic [31:0] host_id,
	output lookup_t     res
);

	logic [31:0]           host_q [HOST_ENTRIES];
	logic [CNT_W-1:0]      used_q;
	logic [HOST_ENTRIES-1:0] hit;
	logic [IDX_W-1:0]      hit_idx;
	logic                  any_hit;
	logic                  full;
	logic                  fresh;

	always_comb begin
		hit = '0;
		hit_idx = '0;
		for (int i = 0; i < HOST_ENTRIES; i++) begin
			hit[i] = (CNT_W'(i) < used_q) && (host_q[i] == host_id);
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign any_hit = |hit;
	assign full    = !any_hit && (used_q == CNT_W'(HOST_ENTRIES));
	assign fresh   = !any_hit && !full;

	assign res.table_full = full;
	assign res.fresh      = fresh;
	assign res.idx        = fresh ? used_q[IDX_W-1:0] : hit_idx;

	always_ff @(posedge clk) begin
		if (en && valid && fresh) begin
			host_q[used_q[IDX_W-1:0]] <= host_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (en && valid && fresh) begin
			used_q <= used_q + CNT_W'(1);
		end
	end

	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("host id matches more than one entry");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(HOST_ENTRIES))
		else $error("entry fill count beyond table size");

endmodule

// ===== sv/acg_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acg_update: per-item counter and limit update
// Applies consume or release to the global count and to one host entry,
// with additive increase on success and halving after a failure run.
// ----------------------------------------------------------------------------
module acg_update import acg_pkg::*; (
	input  logic [1:0]  op,
	input  logic        success,
	input  logic [15:0] limit_cap,
	input  logic [7:0]  timeout_trip,
	input  logic [31:0] glob_cur,
	input  entry_t      cur,
	output logic [31:0] glob_nxt,
	output entry_t      nxt
);

	logic [7:0]  fr;
	logic [15:0] half;

	assign half = cur.limit >> 1;
	assign fr   = (cur.fail_run == '1) ? cur.fail_run : cur.fail_run + 8'd1;

	always_comb begin
		nxt = cur;
		glob_nxt = glob_cur;
		case (op)
			OP_CONSUME: begin
				if (glob_cur != '1) glob_nxt = glob_cur + 32'd1;
				if (cur.inflight != '1) nxt.inflight = cur.inflight + 16'd1;
			end
			OP_RELEASE: begin
				if (glob_cur != '0) glob_nxt = glob_cur - 32'd1;
				if (cur.inflight != '0) nxt.inflight = cur.inflight - 16'd1;
				if (success) begin
					nxt.fail_run = '0;
					if (cur.limit < limit_cap) nxt.limit = cur.limit + 16'd1;
				end else if (fr >= timeout_trip) begin
					nxt.limit = (half == '0) ? 16'd1 : half;
					nxt.fail_run = '0;
				end else begin
					nxt.fail_run = fr;
				end
			end
			default: ;
		endcase
	end

endmodule
